@@ design/plob_pkg.sv @@
package plob_pkg;

  localparam int BOOK_DEPTH = 16;
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 31;
  localparam int IN_QTY_W   = 32;
  localparam int TS_W       = 64;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // Command broadcast to every cell of one side
  typedef struct packed {
    logic               upd;
    logic               positive;
    logic               hi_first;
    logic               any_hit;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cell_cmd_t;

  // One price level as seen by a neighbor
  typedef struct packed {
    logic               v;
    logic [PRICE_W-1:0] p;
    logic [QTY_W-1:0]   q;
  } level_t;

  // Flags that ripple from the best cell toward the worst
  typedef struct packed {
    logic better;
    logic hit_pre;
  } chain_t;

endpackage

@@ design/plob_cell.sv @@
module plob_cell (
  input  logic                clk,
  input  plob_pkg::cell_cmd_t cmd,
  input  logic                own_v,
  input  plob_pkg::level_t    left_lvl,
  input  plob_pkg::level_t    right_lvl,
  input  plob_pkg::chain_t    chain_in,
  output plob_pkg::level_t    lvl,
  output plob_pkg::chain_t    chain_out,
  output logic                match
);

  logic [plob_pkg::PRICE_W-1:0] p_r, p_nxt;
  logic [plob_pkg::QTY_W-1:0]   q_r, q_nxt;
  logic                         better;
  logic                         ins;
  logic                         del;

  always_comb begin
    match  = own_v && (p_r == cmd.price);
    better = !own_v || (cmd.hi_first ? (cmd.price > p_r) : (cmd.price < p_r));
    chain_out.better  = better;
    chain_out.hit_pre = chain_in.hit_pre | match;
    lvl.v = own_v;
    lvl.p = p_r;
    lvl.q = q_r;
  end

  assign ins = cmd.upd && cmd.positive && !cmd.any_hit;
  assign del = cmd.upd && !cmd.positive && cmd.any_hit;

  always_comb begin
    p_nxt = p_r;
    q_nxt = q_r;
    if (ins && better && !chain_in.better) begin
      // first better slot: the new level lands here
      p_nxt = cmd.price;
      q_nxt = cmd.qty;
    end else if (ins && better) begin
      p_nxt = left_lvl.p;
      q_nxt = left_lvl.q;
    end else if (cmd.upd && cmd.positive && match) begin
      q_nxt = cmd.qty;
    end else if (del && chain_out.hit_pre) begin
      p_nxt = right_lvl.p;
      q_nxt = right_lvl.q;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    q_r <= q_nxt;
  end

endmodule

@@ design/plob_side.sv @@
module plob_side (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               upd,
  input  logic                               positive,
  input  logic                               hi_first,
  input  logic [plob_pkg::PRICE_W-1:0]       price,
  input  logic [plob_pkg::QTY_W-1:0]         qty,
  output plob_pkg::level_t                   head,
  output logic [plob_pkg::CNT_W-1:0]         count,
  output logic                               added,
  output logic                               removed
);

  localparam int D = plob_pkg::BOOK_DEPTH;

  logic [plob_pkg::CNT_W-1:0] count_r, count_nxt;
  plob_pkg::cell_cmd_t        cmd;
  plob_pkg::level_t           lvl   [D];
  plob_pkg::chain_t           chain [D+1];
  logic [D-1:0]               match_vec;
  logic [D-1:0]               v_vec;
  logic                       any_hit;

  assign any_hit = |match_vec;

  always_comb begin
    cmd.upd      = upd;
    cmd.positive = positive;
    cmd.hi_first = hi_first;
    cmd.any_hit  = any_hit;
    cmd.price    = price;
    cmd.qty      = qty;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    plob_pkg::level_t left_l, right_l;
    assign v_vec[i] = (count_r > plob_pkg::CNT_W'(i));
    if (i == 0) begin : g_first
      assign left_l = '0;
    end else begin : g_mid
      assign left_l = lvl[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_l = '0;
    end else begin : g_inner
      assign right_l = lvl[i+1];
    end
    plob_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .own_v     (v_vec[i]),
      .left_lvl  (left_l),
      .right_lvl (right_l),
      .chain_in  (chain[i]),
      .lvl       (lvl[i]),
      .chain_out (chain[i+1]),
      .match     (match_vec[i])
    );
  end

  assign added   = upd && positive && !any_hit;
  assign removed = upd && !positive && any_hit;

  always_comb begin
    count_nxt = count_r;
    if (added && (count_r < plob_pkg::CNT_W'(D))) begin
      count_nxt = count_r + 1'b1;
    end else if (removed) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = lvl[0];
  assign count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= plob_pkg::CNT_W'(D))
    else $error("level count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(count_r))
    else $error("level count moved without an update");

  a_remove_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
    removed |-> count_r != '0)
    else $error("delete hit in an empty table");

endmodule

@@ design/price_level_order_book_top.sv @@
// Channel    | Ports                                   | Handshake
// -----------+-----------------------------------------+----------------------------------
// input      | in_side, in_price, in_quantity,         | taken when start & !busy
//            | in_timestamp                            |
// result     | out_has_bid ... out_ask_depth           | out_valid for one cycle, no stall
//
// One transaction is taken per cycle while busy is low. Each table is a row
// of BOOK_DEPTH cells; every cell compares the tick price with its own level
// in parallel and the row shifts by one place toward or away from the best
// end in the accept cycle. Its result shows on the cycle after accept.
// Reset (rst_n low, synchronous) empties both tables and holds busy high
// until the cycle after reset is released. The receiver cannot stall.
module price_level_order_book_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_side,
  input  logic [plob_pkg::PRICE_W-1:0]  in_price,
  input  logic signed [plob_pkg::IN_QTY_W-1:0] in_quantity,
  input  logic [plob_pkg::TS_W-1:0]     in_timestamp,
  output logic                          out_valid,
  output logic                          out_has_bid,
  output logic [plob_pkg::PRICE_W-1:0]  out_bid_top_price,
  output logic [plob_pkg::QTY_W-1:0]    out_bid_top_qty,
  output logic                          out_has_ask,
  output logic [plob_pkg::PRICE_W-1:0]  out_ask_top_price,
  output logic [plob_pkg::QTY_W-1:0]    out_ask_top_qty,
  output logic [plob_pkg::TS_W-1:0]     out_update_time,
  output logic                          out_level_added,
  output logic                          out_level_removed,
  output logic [plob_pkg::CNT_W-1:0]    out_bid_depth,
  output logic [plob_pkg::CNT_W-1:0]    out_ask_depth
);

  logic                          busy_r;
  logic                          accept;
  logic                          positive;
  logic [plob_pkg::QTY_W-1:0]    qty;
  logic                          bid_upd, ask_upd;
  plob_pkg::level_t              bid_head, ask_head;
  logic                          bid_added, bid_removed, ask_added, ask_removed;
  logic                          out_valid_r;
  logic [plob_pkg::TS_W-1:0]     time_r;
  logic                          added_r, removed_r;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // A delete is any quantity that is zero or negative
  assign positive = !in_quantity[plob_pkg::IN_QTY_W-1] && (in_quantity != '0);
  assign qty      = in_quantity[plob_pkg::QTY_W-1:0];

  assign bid_upd = accept && (in_side == plob_pkg::SIDE_BID);
  assign ask_upd = accept && (in_side == plob_pkg::SIDE_ASK);

  plob_side u_bid (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (bid_upd),
    .positive (positive),
    .hi_first (1'b1),
    .price    (in_price),
    .qty      (qty),
    .head     (bid_head),
    .count    (out_bid_depth),
    .added    (bid_added),
    .removed  (bid_removed)
  );

  plob_side u_ask (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (ask_upd),
    .positive (positive),
    .hi_first (1'b0),
    .price    (in_price),
    .qty      (qty),
    .head     (ask_head),
    .count    (out_ask_depth),
    .added    (ask_added),
    .removed  (ask_removed)
  );

  // Hold busy through reset and the cycle after its release
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
    end
  end

  // Capture the per-transaction fields; the tables themselves are read live
  always_ff @(posedge clk) begin
    if (accept) begin
      time_r    <= in_timestamp;
      added_r   <= bid_added | ask_added;
      removed_r <= bid_removed | ask_removed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_has_bid       = bid_head.v;
  assign out_bid_top_price = bid_head.v ? bid_head.p : '0;
  assign out_bid_top_qty   = bid_head.v ? bid_head.q : '0;
  assign out_has_ask       = ask_head.v;
  assign out_ask_top_price = ask_head.v ? ask_head.p : '0;
  assign out_ask_top_qty   = ask_head.v ? ask_head.q : '0;
  assign out_update_time   = time_r;
  assign out_level_added   = added_r;
  assign out_level_removed = removed_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("transaction accepted without a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without a transaction");

  a_add_xor_remove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_level_added && out_level_removed))
    else $error("level both added and removed");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(bid_upd && ask_upd))
    else $error("both tables updated by one transaction");

endmodule

@@ test/price_level_order_book_top_tb.sv @@
module price_level_order_book_top_tb;
  import plob_pkg::*;

  localparam int RAND_TICKS  = 800;
  localparam int CALM_TICKS  = 150;   // no idling over the final stretch
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // Top of book after one tick, one field per result port
  typedef struct packed {
    logic               has_bid;
    logic [PRICE_W-1:0] bid_px;
    logic [QTY_W-1:0]   bid_qt;
    logic               has_ask;
    logic [PRICE_W-1:0] ask_px;
    logic [QTY_W-1:0]   ask_qt;
    logic [TS_W-1:0]    upd_time;
    logic               added;
    logic               removed;
    logic [CNT_W-1:0]   bid_depth;
    logic [CNT_W-1:0]   ask_depth;
  } top_of_book_t;

  // Shadow of both price-level tables plus the queue of expected tops of book
  class book_scoreboard;
    logic [PRICE_W-1:0] lvl_px [2][BOOK_DEPTH];
    logic [QTY_W-1:0]   lvl_qt [2][BOOK_DEPTH];
    int                 lvl_n  [2];
    top_of_book_t       pending_tops [$];
    int                 mismatches;

    function new();
      lvl_n[0]   = 0;
      lvl_n[1]   = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_tops.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Apply one accepted tick to the shadow book and queue its top of book
    function void note_tick(logic side, logic [PRICE_W-1:0] px,
                            logic signed [IN_QTY_W-1:0] q, logic [TS_W-1:0] ts);
      top_of_book_t e;
      int           s;
      int           n;
      int           hit;
      int           pos;
      int           i;
      bit           hi_first;
      bit           better;
      s        = (side == SIDE_ASK) ? 1 : 0;
      hi_first = (side == SIDE_BID);
      n        = lvl_n[s];
      hit      = n;
      pos      = n;
      e        = '0;
      for (i = 0; i < n; i++) begin
        if (lvl_px[s][i] == px) begin
          hit = i;
          break;
        end
      end
      if (q > 0) begin
        if (hit < n) begin
          lvl_qt[s][hit] = q[QTY_W-1:0];
        end else begin
          e.added = 1'b1;
          for (i = 0; i < n; i++) begin
            better = hi_first ? (px > lvl_px[s][i]) : (px < lvl_px[s][i]);
            if (better) begin
              pos = i;
              break;
            end
          end
          // a level worse than all of a full table simply falls off
          if (pos < BOOK_DEPTH) begin
            for (i = (n < BOOK_DEPTH) ? n : BOOK_DEPTH - 1; i > pos; i--) begin
              lvl_px[s][i] = lvl_px[s][i-1];
              lvl_qt[s][i] = lvl_qt[s][i-1];
            end
            lvl_px[s][pos] = px;
            lvl_qt[s][pos] = q[QTY_W-1:0];
            if (n < BOOK_DEPTH)
              lvl_n[s] = n + 1;
          end
        end
      end else if (hit < n) begin
        for (i = hit; i + 1 < n; i++) begin
          lvl_px[s][i] = lvl_px[s][i+1];
          lvl_qt[s][i] = lvl_qt[s][i+1];
        end
        lvl_n[s]  = n - 1;
        e.removed = 1'b1;
      end
      e.has_bid   = (lvl_n[0] > 0);
      e.bid_px    = e.has_bid ? lvl_px[0][0] : '0;
      e.bid_qt    = e.has_bid ? lvl_qt[0][0] : '0;
      e.has_ask   = (lvl_n[1] > 0);
      e.ask_px    = e.has_ask ? lvl_px[1][0] : '0;
      e.ask_qt    = e.has_ask ? lvl_qt[1][0] : '0;
      e.upd_time  = ts;
      e.bid_depth = lvl_n[0][CNT_W-1:0];
      e.ask_depth = lvl_n[1][CNT_W-1:0];
      pending_tops.push_back(e);
    endfunction

    // Compare one result transaction with the oldest expected top of book
    function void check_result(top_of_book_t got);
      top_of_book_t want;
      if (pending_tops.size() == 0) begin
        flag("result with no tick outstanding");
        return;
      end
      want = pending_tops.pop_front();
      if (got.has_bid !== want.has_bid)
        flag($sformatf("has_bid exp %0h got %0h", want.has_bid, got.has_bid));
      if (got.bid_px !== want.bid_px)
        flag($sformatf("bid_top_price exp %0h got %0h", want.bid_px, got.bid_px));
      if (got.bid_qt !== want.bid_qt)
        flag($sformatf("bid_top_qty exp %0h got %0h", want.bid_qt, got.bid_qt));
      if (got.has_ask !== want.has_ask)
        flag($sformatf("has_ask exp %0h got %0h", want.has_ask, got.has_ask));
      if (got.ask_px !== want.ask_px)
        flag($sformatf("ask_top_price exp %0h got %0h", want.ask_px, got.ask_px));
      if (got.ask_qt !== want.ask_qt)
        flag($sformatf("ask_top_qty exp %0h got %0h", want.ask_qt, got.ask_qt));
      if (got.upd_time !== want.upd_time)
        flag($sformatf("update_time exp %0h got %0h", want.upd_time, got.upd_time));
      if (got.added !== want.added)
        flag($sformatf("level_added exp %0h got %0h", want.added, got.added));
      if (got.removed !== want.removed)
        flag($sformatf("level_removed exp %0h got %0h", want.removed, got.removed));
      if (got.bid_depth !== want.bid_depth)
        flag($sformatf("bid_depth exp %0d got %0d", want.bid_depth, got.bid_depth));
      if (got.ask_depth !== want.ask_depth)
        flag($sformatf("ask_depth exp %0d got %0d", want.ask_depth, got.ask_depth));
    endfunction
  endclass

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        start        = 1'b0;
  logic                        in_side      = SIDE_BID;
  logic [PRICE_W-1:0]          in_price     = '0;
  logic signed [IN_QTY_W-1:0]  in_quantity  = '0;
  logic [TS_W-1:0]             in_timestamp = '0;
  logic                        busy;
  logic                        out_valid;
  logic                        out_has_bid;
  logic [PRICE_W-1:0]          out_bid_top_price;
  logic [QTY_W-1:0]            out_bid_top_qty;
  logic                        out_has_ask;
  logic [PRICE_W-1:0]          out_ask_top_price;
  logic [QTY_W-1:0]            out_ask_top_qty;
  logic [TS_W-1:0]             out_update_time;
  logic                        out_level_added;
  logic                        out_level_removed;
  logic [CNT_W-1:0]            out_bid_depth;
  logic [CNT_W-1:0]            out_ask_depth;

  book_scoreboard book = new();
  int             cycles = 0;

  price_level_order_book_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_side           (in_side),
    .in_price          (in_price),
    .in_quantity       (in_quantity),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_has_bid       (out_has_bid),
    .out_bid_top_price (out_bid_top_price),
    .out_bid_top_qty   (out_bid_top_qty),
    .out_has_ask       (out_has_ask),
    .out_ask_top_price (out_ask_top_price),
    .out_ask_top_qty   (out_ask_top_qty),
    .out_update_time   (out_update_time),
    .out_level_added   (out_level_added),
    .out_level_removed (out_level_removed),
    .out_bid_depth     (out_bid_depth),
    .out_ask_depth     (out_ask_depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("price_level_order_book_top_tb NOT OK");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Check first: a result seen at this
  // edge belongs to a tick taken at an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        book.check_result({out_has_bid, out_bid_top_price, out_bid_top_qty,
                           out_has_ask, out_ask_top_price, out_ask_top_qty,
                           out_update_time, out_level_added, out_level_removed,
                           out_bid_depth, out_ask_depth});
      if (start && !busy)
        book.note_tick(in_side, in_price, in_quantity, in_timestamp);
    end
  end

  // Present one tick at the falling edge and hold it until the block takes it.
  // Leave start high on return so back-to-back ticks stream without a gap.
  task automatic send_tick(logic side, logic [PRICE_W-1:0] px,
                           logic signed [IN_QTY_W-1:0] q, logic [TS_W-1:0] ts);
    @(negedge clk);
    start        <= 1'b1;
    in_side      <= side;
    in_price     <= px;
    in_quantity  <= q;
    in_timestamp <= ts;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_for(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_book();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  logic [PRICE_W-1:0] win_base;
  int                 del_pct;

  // Random tick: prices mostly in a narrow window so levels get hit, filled
  // past depth and deleted again; the rest random over the range or at its ends.
  task automatic random_tick();
    logic               side;
    logic [PRICE_W-1:0] px;
    logic [IN_QTY_W-1:0] q;
    int                 r;
    side = $urandom_range(0, 1) ? SIDE_ASK : SIDE_BID;
    r    = $urandom_range(0, 99);
    if (r < 78)      px = win_base + $urandom_range(0, 39);
    else if (r < 90) px = $urandom;
    else             px = $urandom_range(0, 1) ? '1 : '0;
    r = $urandom_range(0, 99);
    if (r >= del_pct) begin
      r = $urandom_range(0, 9);
      if (r < 6)      q = $urandom_range(1, 1000);
      else if (r < 9) q = $urandom & 32'h7fff_ffff;
      else            q = 32'h7fff_ffff;
      if (q == 0) q = 1;
    end else begin
      r = $urandom_range(0, 3);
      case (r)
        0:       q = '0;
        1:       q = '1;
        2:       q = $urandom | 32'h8000_0000;
        default: q = 32'h8000_0000;
      endcase
    end
    send_tick(side, px, q, {$urandom, $urandom});
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-side reads, extremes, overwrite, deletes present and absent
    send_tick(SIDE_BID, 32'd5, 32'sd0, '0);                       // delete on empty book
    send_tick(SIDE_BID, 32'd100, 32'sd1, 64'd1);
    send_tick(SIDE_BID, 32'hffff_ffff, 32'sh7fff_ffff, 64'd2);    // new best bid
    send_tick(SIDE_BID, 32'd0, 32'sd5, 64'd3);                    // worst bid
    send_tick(SIDE_BID, 32'd100, 32'sd77, 64'd4);                 // overwrite
    send_tick(SIDE_ASK, 32'd0, 32'sd3, 64'd5);
    send_tick(SIDE_ASK, 32'hffff_ffff, 32'sd9, 64'd6);
    send_tick(SIDE_ASK, 32'd0, 32'sh7fff_ffff, 64'd7);            // overwrite best ask
    send_tick(SIDE_BID, 32'd100, -32'sd1, 64'd8);                 // delete middle level
    send_tick(SIDE_BID, 32'd100, 32'sh8000_0000, '1);             // delete absent
    send_tick(SIDE_ASK, 32'd0, 32'sd0, 64'h8000_0000_0000_0000);  // delete best ask
    // Fill the ask table to full depth, then push past it
    for (int i = 0; i < BOOK_DEPTH - 1; i++)
      send_tick(SIDE_ASK, 32'd10 + i, 32'sd20 + i, 64'd100 + i);
    send_tick(SIDE_ASK, 32'd1000, 32'sd1, 64'd200);               // evict the worst
    send_tick(SIDE_ASK, 32'd2000, 32'sd2, 64'd201);               // worse than all: dropped
    drain_book();

    // Random: new price window and delete rate every 100 ticks
    for (int k = 0; k < RAND_TICKS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       win_base = 32'd0;
          1:       win_base = 32'hffff_ffff - 32'd39;
          default: win_base = $urandom;
        endcase
        del_pct = $urandom_range(15, 60);
      end
      if (k % 200 == 199 && k < RAND_TICKS - CALM_TICKS)
        drain_book();
      if (k < RAND_TICKS - CALM_TICKS && $urandom_range(0, 5) == 0)
        idle_for($urandom_range(1, 13));
      random_tick();
    end

    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0)
      $display("price_level_order_book_top_tb OK");
    else
      $display("price_level_order_book_top_tb NOT OK");
    $finish;
  end

endmodule
